/* rtl/prq_pkg.sv */
`timescale 1ns / 1ps
package prq_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int TAG_BITS    = 16;

  localparam int IDX_W  = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W  = $clog2(2 * QUEUE_DEPTH);
  localparam int CFG_W  = 11;
  localparam int CIDX_W = 2;
  localparam int TAG_W  = 16;
  localparam int ETAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int CMP_W  = ((CFG_W > LEN_W) ? CFG_W : LEN_W) + 1;
  localparam int SGN_W  = ((CNT_W > CMP_W) ? CNT_W : CMP_W) + 2;

  localparam logic [CFG_W-1:0] DEF_LENGTH = CFG_W'(1024);
  localparam logic [CFG_W-1:0] DEF_STOP   = CFG_W'(128);
  localparam logic [CFG_W-1:0] DEF_RESUME = CFG_W'(512);
  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(2 * QUEUE_DEPTH - 1);

  localparam logic [2:0] CC_NOT_DONE = 3'd0;
  localparam logic [2:0] CC_GOOD     = 3'd1;
  localparam logic [2:0] CC_WARN     = 3'd2;
  localparam logic [1:0] UC_OK       = 2'd0;
  localparam logic [1:0] UC_SG_LEN   = 2'd1;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ENABLE, CFG_LENGTH, CFG_STOP, CFG_RESUME
  } cfg_idx_t;

  typedef enum logic [0:0] {
    OP_SUBMIT, OP_POLL
  } op_t;

  typedef enum logic [2:0] {
    K_ACCEPT, K_STOP, K_FULL, K_NOSTART, K_EMPTY, K_NOTDONE, K_RESUME, K_DONE
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_RES, S_DONE
  } state_t;

  typedef struct packed {
    logic              busy;
    logic              resume;
    logic              trunc;
    logic [ETAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic  capture;
    logic  clr_write;
    logic  sub_commit;
    logic  rd_resume;
    logic  res_clear;
    logic  done_commit;
    logic  out_load;
    kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic enabled;
    logic busy;
    logic resume;
    logic cc_zero;
    logic stop;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/pending_ring_with_backpressure.sv */
`timescale 1ns / 1ps
// Pending-request ring with busy marks and stop/resume flow control.
// Input channel (in_valid/in_ready): one transaction is a submit (op 0) or a
// poll of the front entry (op 1). Output channel (out_valid/out_ready): one
// transaction per result; a poll that completes an entry may give a resume
// result (last 0) ahead of its completion result (last 1).
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once
// (0 enable, 1 length, 2 stop margin, 3 resume margin); write only when idle.
// Steps: every item costs one lookup read of the entry store (a single
// write and single read port RAM, registered read). A submit or a poll that
// finds the front empty or not done gives its result from that lookup; a
// completing poll reads the front entry, then the entry a resume margin
// ahead, then frees the front entry, giving any resume result before the
// completion. A new item is taken only once the block is back in idle
// after the last. The resume step is taken whether or not a resume result
// is given.
// Reset: after rst falls the store is swept, one entry a cycle, clearing busy
// and resume marks: in_ready stays low until the last entry is cleared.
// Stalls: a result waits in the output register while the next transaction
// may already be accepted; the block holds in its current step until the
// output register is free for the next result.
module pending_ring_with_backpressure (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic                        may_sleep,
  input  logic [prq_pkg::TAG_W-1:0]   request_tag,
  input  logic                        trunc_hmac,
  input  logic [2:0]                  comp_code,
  input  logic [1:0]                  uc_class,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  kind,
  output logic [prq_pkg::TAG_W-1:0]   result_tag,
  output logic                        status,
  output logic                        last,
  input  logic                        cfg_we,
  input  logic [prq_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [prq_pkg::CFG_W-1:0]   cfg_wdata
);
  import prq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: clearing sweep, lookup, resume check, completion
  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // pointers, count, entry store, configuration and result register
  prq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .op          (op),
    .may_sleep   (may_sleep),
    .request_tag (request_tag),
    .trunc_hmac  (trunc_hmac),
    .comp_code   (comp_code),
    .uc_class    (uc_class),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .result_tag  (result_tag),
    .status      (status),
    .last        (last)
  );

endmodule

/* rtl/prq_ram.sv */
`timescale 1ns / 1ps
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/prq_ctrl.sv */
`timescale 1ns / 1ps
module prq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  prq_pkg::stat_t st,
  output prq_pkg::cmd_t  cmd
);
  import prq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.out_kind = K_ACCEPT;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (st.op == OP_SUBMIT) begin
          if (!st.enabled) begin
            cmd.out_kind = K_NOSTART;
          end else if (st.busy) begin
            cmd.out_kind = K_FULL;
          end else if (st.stop) begin
            cmd.out_kind = K_STOP;
          end else begin
            cmd.out_kind = K_ACCEPT;
          end
          if (st.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.sub_commit = st.enabled && !st.busy;
            state_next     = S_IDLE;
          end
        end else if (!st.busy || st.cc_zero) begin
          cmd.out_kind = st.busy ? K_NOTDONE : K_EMPTY;
          if (st.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.rd_resume = 1'b1;
          state_next    = S_RES;
        end
      end
      S_RES: begin
        cmd.out_kind = K_RESUME;
        if (!st.resume) begin
          state_next = S_DONE;
        end else if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.res_clear = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_kind = K_DONE;
        if (st.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.done_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_looks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOOK))
    else $error("accepted item did not start a lookup");

  a_done_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && st.out_free) |=> (state == S_IDLE))
    else $error("completion did not return to idle");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && st.clr_last) |=> (state == S_IDLE))
    else $error("clearing sweep did not end in idle");

endmodule

/* rtl/prq_datapath.sv */
`timescale 1ns / 1ps
module prq_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  prq_pkg::cmd_t               cmd,
  output prq_pkg::stat_t              st,
  input  logic                        op,
  input  logic                        may_sleep,
  input  logic [prq_pkg::TAG_W-1:0]   request_tag,
  input  logic                        trunc_hmac,
  input  logic [2:0]                  comp_code,
  input  logic [1:0]                  uc_class,
  input  logic                        cfg_we,
  input  logic [prq_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [prq_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  kind,
  output logic [prq_pkg::TAG_W-1:0]   result_tag,
  output logic                        status,
  output logic                        last
);
  import prq_pkg::*;

  function automatic logic [IDX_W-1:0] advance(logic [IDX_W-1:0] idx,
                                               logic [LEN_W-1:0] len_v,
                                               logic [CFG_W-1:0] inc);
    logic [CMP_W-1:0] stride;
    logic [CMP_W:0]   s;
    stride = (CMP_W'(inc) > CMP_W'(len_v)) ? CMP_W'(len_v) : CMP_W'(inc);
    s = (CMP_W+1)'(idx) + (CMP_W+1)'(stride);
    if (s >= (CMP_W+1)'(len_v)) s = s - (CMP_W+1)'(len_v);
    if (s >= (CMP_W+1)'(len_v)) s = '0;
    return IDX_W'(s);
  endfunction

  // configuration
  logic             enabled;
  logic [CFG_W-1:0] qlen, stop_m, res_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      qlen    <= DEF_LENGTH;
      stop_m  <= DEF_STOP;
      res_m   <= DEF_RESUME;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE: enabled <= cfg_wdata[0];
        CFG_LENGTH: qlen    <= cfg_wdata;
        CFG_STOP:   stop_m  <= cfg_wdata;
        CFG_RESUME: res_m   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] len;

  always_comb begin
    if (qlen == '0) begin
      len = LEN_W'(1);
    end else if (CMP_W'(qlen) > CMP_W'(QUEUE_DEPTH)) begin
      len = LEN_W'(QUEUE_DEPTH);
    end else begin
      len = LEN_W'(qlen);
    end
  end

  // ring pointers, count, clearing sweep
  logic [IDX_W-1:0] front, rear, f_n, r_n, ri, ri_q, clr_cnt;
  logic [CNT_W-1:0] count;

  assign f_n = (LEN_W'(front) >= len) ? '0 : front;
  assign r_n = (LEN_W'(rear) >= len) ? '0 : rear;
  assign ri  = advance(f_n, len, res_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      rear    <= '0;
      count   <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      // every transaction pulls an index left beyond a shrunk ring back to 0
      if (cmd.capture) begin
        front <= f_n;
        rear  <= r_n;
      end
      if (cmd.sub_commit) begin
        rear <= advance(r_n, len, CFG_W'(1));
        if (count < CNT_MAX) begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.done_commit) begin
        front <= advance(f_n, len, CFG_W'(1));
        if (count != '0) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // captured transaction
  op_t               op_q;
  logic              may_q, trunc_q;
  logic [ETAG_W-1:0] tag_q;
  logic [2:0]        cc_q;
  logic [1:0]        uc_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(op);
      may_q   <= may_sleep;
      tag_q   <= ETAG_W'(request_tag);
      trunc_q <= trunc_hmac;
      cc_q    <= comp_code;
      uc_q    <= uc_class;
    end
  end

  // entry store
  entry_t           rd_word, wr_word, front_word;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic             stop;

  assign stop = may_q && ($signed(SGN_W'(count)) >
                          $signed(SGN_W'(len)) - $signed(SGN_W'(stop_m)));

  assign re    = cmd.capture || cmd.rd_resume;
  assign raddr = cmd.capture ? ((op_t'(op) == OP_POLL) ? f_n : r_n) : ri;

  always_comb begin
    we      = 1'b0;
    waddr   = clr_cnt;
    wr_word = '0;
    if (cmd.sub_commit) begin
      we      = 1'b1;
      waddr   = r_n;
      wr_word = '{busy: 1'b1, resume: stop, trunc: trunc_q, tag: tag_q};
    end else if (cmd.res_clear) begin
      we             = 1'b1;
      waddr          = ri_q;
      wr_word        = rd_word;
      wr_word.resume = 1'b0;
    end else if (cmd.done_commit) begin
      we             = 1'b1;
      waddr          = f_n;
      wr_word        = front_word;
      wr_word.busy   = 1'b0;
      wr_word.resume = 1'b0;
    end else if (cmd.clr_write) begin
      we = 1'b1;
    end
  end

  prq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_word),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_resume) begin
      front_word <= rd_word;
      ri_q       <= ri;
    end
  end

  // completion classification
  logic comp_ok;

  assign comp_ok = (cc_q == CC_GOOD || cc_q == CC_WARN) &&
                   (uc_q == UC_OK || (uc_q == UC_SG_LEN && front_word.trunc));

  // result register
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind <= cmd.out_kind;
      last <= (cmd.out_kind != K_RESUME);
      case (cmd.out_kind)
        K_RESUME: begin
          result_tag <= TAG_W'(rd_word.tag);
          status     <= 1'b0;
        end
        K_DONE: begin
          result_tag <= TAG_W'(front_word.tag);
          status     <= !comp_ok;
        end
        default: begin
          result_tag <= '0;
          status     <= 1'b0;
        end
      endcase
    end
  end

  assign st = '{op: op_q, enabled: enabled, busy: rd_word.busy,
                resume: rd_word.resume, cc_zero: (cc_q == CC_NOT_DONE),
                stop: stop, clr_last: (clr_cnt == IDX_W'(QUEUE_DEPTH - 1)),
                out_free: out_free};

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_write, cmd.sub_commit, cmd.res_clear, cmd.done_commit}))
    else $error("more than one store write at once");

  a_rear_hold: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sub_commit || cmd.capture) |=> $stable(rear))
    else $error("rear moved without a submit");

endmodule

/* tb/tb_pending_ring_with_backpressure.sv */
`timescale 1ns / 1ps
// Self-checking bench for the pending ring.
// Submit and poll transactions are queued by the stimulus process and fed by
// a clocked driver; an independent predictor, updated when the block takes a
// transaction, queues the results it should give, and a clocked monitor
// compares every result transaction against the oldest one waiting.
module tb_pending_ring_with_backpressure;
  import prq_pkg::*;

  localparam int STALL_LIMIT   = 4000; // idle cycles allowed, clear pass included
  localparam int SETTLE_CYCLES = 4;    // extra wait once every result is back

  // Completion and microcode codes the package leaves unnamed
  localparam logic [2:0] CC_FAULT     = 3'd3;
  localparam logic [2:0] CC_HW_ERR    = 3'd4;
  localparam logic [2:0] CC_INSTR_ERR = 3'd5;
  localparam logic [2:0] CC_INVALID   = 3'd6;
  localparam logic [2:0] CC_UNDEF     = 3'd7;
  localparam logic [1:0] UC_OTHER     = 2'd2;
  localparam logic [1:0] UC_UNDEF     = 2'd3;

  typedef struct {
    op_t              op;
    logic             may_sleep;
    logic [TAG_W-1:0] tag;
    logic             trunc;
    logic [2:0]       cc;
    logic [1:0]       uc;
  } ring_req_t;

  typedef struct {
    kind_t            kind;
    logic [TAG_W-1:0] tag;
    logic             status;
    logic             last;
  } ring_resp_t;

  // DUT signals: every input known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              op = 1'b0;
  logic              may_sleep = 1'b0;
  logic [TAG_W-1:0]  request_tag = '0;
  logic              trunc_hmac = 1'b0;
  logic [2:0]        comp_code = '0;
  logic [1:0]        uc_class = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        kind;
  logic [TAG_W-1:0]  result_tag;
  logic              status;
  logic              last;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  pending_ring_with_backpressure uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .may_sleep(may_sleep), .request_tag(request_tag),
    .trunc_hmac(trunc_hmac), .comp_code(comp_code), .uc_class(uc_class),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .result_tag(result_tag), .status(status), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stimulus and expectation stores
  ring_req_t   pending_items[$];
  ring_resp_t  expected_results[$];
  int unsigned idle_pct = 0;     // chance per transaction of an idle burst, or of an output stall
  int unsigned mismatch_count = 0;

  // Predictor copy of the registers (reset values)
  logic             ring_on    = 1'b0;
  logic [CFG_W-1:0] ring_len   = DEF_LENGTH;
  logic [CFG_W-1:0] stop_gap   = DEF_STOP;
  logic [CFG_W-1:0] resume_gap = DEF_RESUME;

  // Predictor copy of the ring
  bit             ring_busy   [QUEUE_DEPTH];
  bit             ring_resume [QUEUE_DEPTH];
  bit             ring_trunc  [QUEUE_DEPTH];
  bit [TAG_W-1:0] ring_tag    [QUEUE_DEPTH];
  logic [IDX_W-1:0] front_idx = '0;
  logic [IDX_W-1:0] rear_idx  = '0;
  logic [CNT_W-1:0] pend_cnt  = '0;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Step an index round the ring: one conditional wrap, then zero if still
  // outside a shrunk ring.
  function automatic int unsigned ring_next(int unsigned idx, int unsigned len,
                                            int unsigned inc);
    int unsigned s;
    if (inc > len) inc = len;
    s = idx + inc;
    if (s >= len) s -= len;
    if (s >= len) s = 0;
    return s;
  endfunction

  function automatic void expect_result(kind_t k, logic [TAG_W-1:0] t, logic s, logic l);
    ring_resp_t r;
    r.kind = k; r.tag = t; r.status = s; r.last = l;
    expected_results.push_back(r);
  endfunction

  // Work out the results of one accepted transaction and update the ring.
  function automatic void predict_ring(ring_req_t r);
    int unsigned len, slot, ahead;
    logic        stop_now, good;
    len = (ring_len == 0) ? 1 : (ring_len > QUEUE_DEPTH) ? QUEUE_DEPTH : ring_len;
    if (front_idx >= len) front_idx = '0;
    if (rear_idx >= len) rear_idx = '0;
    if (r.op == OP_SUBMIT) begin
      slot = 32'(rear_idx);
      if (!ring_on) begin
        expect_result(K_NOSTART, '0, 1'b0, 1'b1);
      end else if (ring_busy[slot]) begin
        expect_result(K_FULL, '0, 1'b0, 1'b1);
      end else begin
        rear_idx = IDX_W'(ring_next(slot, len, 1));
        // signed: the margin may exceed the length
        stop_now = r.may_sleep && (int'(pend_cnt) > int'(len) - int'(stop_gap));
        ring_resume[slot] = stop_now;
        if (pend_cnt < CNT_MAX) pend_cnt++;
        ring_tag[slot]   = r.tag;
        ring_trunc[slot] = r.trunc;
        ring_busy[slot]  = 1'b1;
        expect_result(stop_now ? K_STOP : K_ACCEPT, '0, 1'b0, 1'b1);
      end
    end else begin
      slot = 32'(front_idx);
      if (!ring_busy[slot]) begin
        expect_result(K_EMPTY, '0, 1'b0, 1'b1);
      end else if (r.cc == CC_NOT_DONE) begin
        expect_result(K_NOTDONE, '0, 1'b0, 1'b1);
      end else begin
        good = (r.cc == CC_GOOD || r.cc == CC_WARN) &&
               (r.uc == UC_OK || (r.uc == UC_SG_LEN && ring_trunc[slot]));
        ahead = ring_next(slot, len, 32'(resume_gap));
        if (ring_resume[ahead]) begin
          ring_resume[ahead] = 1'b0;
          expect_result(K_RESUME, ring_tag[ahead], 1'b0, 1'b0);
        end
        expect_result(K_DONE, ring_tag[slot], !good, 1'b1);
        ring_busy[slot]   = 1'b0;
        ring_resume[slot] = 1'b0;
        if (pend_cnt > 0) pend_cnt--;
        front_idx = IDX_W'(ring_next(slot, len, 1));
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued transactions, idles in short random bursts.
  // A transaction is handed to the predictor on the edge it is taken.
  // ---------------------------------------------------------------------
  ring_req_t   cur_item;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : feed
    logic taken;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) predict_ring(cur_item);
      if (!in_valid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          op          <= cur_item.op;
          may_sleep   <= cur_item.may_sleep;
          request_tag <= cur_item.tag;
          trunc_hmac  <= cur_item.trunc;
          comp_code   <= cur_item.cc;
          uc_class    <= cur_item.uc;
          in_valid    <= 1'b1;
          // idle burst after this transaction has gone
          if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result transaction, stalls the block at random.
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin : sink
    ring_resp_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result kind", 32'(kind), 'x);
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind)
            report_mismatch("kind", 32'(kind), 32'(want.kind));
          if (result_tag !== want.tag)
            report_mismatch("result_tag", 32'(result_tag), 32'(want.tag));
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (last !== want.last)
            report_mismatch("last", 32'(last), 32'(want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no transaction on either side ends the run
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_submit(logic ms, logic [TAG_W-1:0] t, logic tr);
    ring_req_t r;
    r.op = OP_SUBMIT; r.may_sleep = ms; r.tag = t; r.trunc = tr;
    r.cc = 3'($urandom); r.uc = 2'($urandom);
    pending_items.push_back(r);
  endtask

  task automatic add_poll(logic [2:0] cc, logic [1:0] uc);
    ring_req_t r;
    r.op = OP_POLL; r.may_sleep = 1'($urandom); r.tag = TAG_W'($urandom);
    r.trunc = 1'($urandom);
    r.cc = cc; r.uc = uc;
    pending_items.push_back(r);
  endtask

  // Random traffic in runs of 16 that lean towards filling or draining,
  // so the ring regularly reaches full and the stop/resume marks get used.
  task automatic queue_random(int unsigned n);
    ring_req_t   r;
    int unsigned lean;
    lean = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 16 == 0) lean = $urandom_range(0, 1) ? 75 : 30;
      r.op        = ($urandom_range(0, 99) < lean) ? OP_SUBMIT : OP_POLL;
      r.may_sleep = 1'($urandom);
      r.tag       = TAG_W'($urandom);
      r.trunc     = 1'($urandom);
      r.cc        = 3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(1, 2));
      r.uc        = 2'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 1));
      pending_items.push_back(r);
    end
  endtask

  // Wait until everything sent has been taken and answered; looked at just
  // after the edge so the driver's updates of that edge are seen.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ENABLE: ring_on    = val[0];
      CFG_LENGTH: ring_len   = val;
      CFG_STOP:   stop_gap   = val;
      CFG_RESUME: resume_gap = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [CFG_W-1:0] en, logic [CFG_W-1:0] len,
                               logic [CFG_W-1:0] stp, logic [CFG_W-1:0] res);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_STOP, stp);
    write_reg(CFG_RESUME, res);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One setting: program while idle, then random traffic with a full drain
  // half way, where the sender holds off until every result is back.
  task automatic run_phase(logic [CFG_W-1:0] en, logic [CFG_W-1:0] len,
                           logic [CFG_W-1:0] stp, logic [CFG_W-1:0] res,
                           int unsigned n, int unsigned pct);
    wait_idle();
    apply_setting(en, len, stp, res);
    idle_pct = pct;
    queue_random(n / 2);
    wait_idle();
    queue_random(n - n / 2);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Not started yet: submits refused, poll finds nothing
    idle_pct = 20;
    add_submit(1'b1, 16'h5A5A, 1'b1);
    add_poll(CC_GOOD, UC_OK);
    wait_idle();

    // Four entries, stop when more than two are pending, resume one ahead
    apply_setting(11'h001, 11'd4, 11'd2, 11'd1);
    add_poll(CC_GOOD, UC_OK);                // empty ring
    add_submit(1'b0, 16'h0000, 1'b0);
    add_submit(1'b1, 16'hFFFF, 1'b1);
    add_submit(1'b1, 16'h1234, 1'b0);
    add_submit(1'b1, 16'hABCD, 1'b1);        // nearly full: sender told to stop
    add_submit(1'b0, 16'h5555, 1'b0);        // ring full
    add_poll(CC_NOT_DONE, UC_OK);
    add_poll(CC_GOOD, UC_OK);                // success
    add_poll(CC_WARN, UC_SG_LEN);            // sg length error forgiven on truncated hmac
    add_poll(CC_GOOD, UC_SG_LEN);            // not truncated: error, resume ahead
    add_poll(CC_UNDEF, UC_OK);               // undefined completion code
    add_poll(CC_FAULT, UC_OK);               // empty again
    add_submit(1'b0, 16'h7FFF, 1'b1);
    add_submit(1'b1, 16'h8000, 1'b0);
    add_submit(1'b0, 16'h00FF, 1'b1);
    add_submit(1'b1, 16'hFF00, 1'b0);
    add_poll(CC_FAULT, UC_OK);
    add_poll(CC_HW_ERR, UC_OTHER);
    add_poll(CC_INSTR_ERR, UC_UNDEF);
    add_poll(CC_INVALID, UC_OK);
    add_poll(CC_WARN, UC_OTHER);

    // Settings: small rings, degenerate lengths and margins, shrink while
    // entries are pending, stop, full-depth ring.
    run_phase(11'h001, 11'd8,    11'd3,    11'd5,    200, 30);
    run_phase(11'h001, 11'd1,    11'd0,    11'd0,     80,  0);
    run_phase(11'h7FF, 11'd0,    11'h7FF,  11'h7FF,   60, 40);
    run_phase(11'h001, 11'd16,   11'd1024, 11'h7FF,  150, 20);
    run_phase(11'h001, 11'd5,    11'd2,    11'd3,    120, 50);
    run_phase(11'h7FE, 11'd5,    11'd2,    11'd3,     40, 25);
    run_phase(11'h001, 11'h7FF,  11'd128,  11'd512,  350, 15);
    run_phase(11'h001, 11'd1024, 11'd0,    11'd1024, 150,  0);

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_ctrl.sv
rtl/prq_datapath.sv
rtl/pending_ring_with_backpressure.sv
tb/tb_pending_ring_with_backpressure.sv
